FILE: rtl/core/abbreviation_optimal_parse_unit_assert.svh
// Assertion macros shared by the parse unit RTL.
// AOP_ASSERT checks a property on every clock edge outside reset.
// AOP_ASSERT_NEXT checks that cons holds in the cycle after ante.
`ifndef ABBREVIATION_OPTIMAL_PARSE_UNIT_ASSERT_SVH
`define ABBREVIATION_OPTIMAL_PARSE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define AOP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("aop: assertion failed");
`define AOP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("aop: assertion failed");
`else
`define AOP_ASSERT(lbl, prop)
`define AOP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/core/aop_pkg.sv
package aop_pkg;

  localparam int unsigned NUM_ABBREVS    = 96;
  localparam logic [3:0]  REF_COST_RESET = 4'd2;
  // ceil(2^19 / 3): x / 3 == (x * DIV3_MAGIC) >> 19 for x < 2^19
  localparam logic [17:0] DIV3_MAGIC     = 18'h2AAAB;

  // request kinds on the func field
  localparam logic FUNC_CHAR = 1'b0;
  localparam logic FUNC_CAND = 1'b1;

  typedef struct packed {
    logic       func;
    logic [3:0] glyph_cost;
    logic [6:0] abbrev_id;
    logic [6:0] abbrev_length;
    logic [7:0] abbrev_weight;
    logic       first_of_line;
    logic       last_of_position;
    logic       last_of_line;
    logic [3:0] rounding_unit;
  } in_req_t;

  typedef struct packed {
    logic [15:0] position_cost;
    logic        picked_valid;
    logic [6:0]  picked_id;
    logic        line_done;
    logic [3:0]  rounding_cost;
    logic [15:0] line_bytes;
  } out_req_t;

  typedef struct packed {
    logic [3:0]  rounding_cost;
    logic [15:0] line_bytes;
  } line_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_LINE,
    ST_EMIT
  } parse_state_e;

  typedef enum logic [2:0] {
    DV_IDLE,
    DV_RUN,
    DV_SUM,
    DV_MUL,
    DV_DONE
  } div_state_e;

  function automatic logic [15:0] sat_add(logic [15:0] a, logic [3:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {13'd0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

endpackage

FILE: rtl/core/aop_window.sv
`include "abbreviation_optimal_parse_unit_assert.svh"

module aop_window #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     clr_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_k_i,
  input  logic                     push_i,
  input  logic [15:0]              push_data_i,
  output logic [15:0]              rd_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned IW = AW + 1;
  localparam int unsigned FW = $clog2(DEPTH + 1);

  // circular buffer: entry k back from the newest sits at ptr - 1 - k
  logic [15:0]   mem_q [DEPTH];
  logic [15:0]   rd_q;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [FW-1:0] fill_q, fill_d;
  logic          hit_q, hit_d;
  logic [IW-1:0] idx_sum;
  logic [AW-1:0] rd_idx;

  always_comb begin
    idx_sum = IW'(ptr_q) + IW'(DEPTH - 1) - IW'(rd_k_i);
    rd_idx  = (idx_sum >= IW'(DEPTH)) ? AW'(idx_sum - IW'(DEPTH)) : AW'(idx_sum);
  end

  always_comb begin
    ptr_d  = ptr_q;
    fill_d = fill_q;
    hit_d  = hit_q;
    if (clr_i) begin
      fill_d = '0;
    end
    if (rd_en_i) begin
      // entries beyond the fill count belong past the line end: cost zero
      hit_d = !clr_i && (FW'(rd_k_i) < fill_q);
    end
    if (push_i) begin
      ptr_d = (ptr_q == AW'(DEPTH - 1)) ? '0 : ptr_q + AW'(1);
      if (fill_q != FW'(DEPTH)) begin
        fill_d = fill_q + FW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      fill_q <= '0;
      hit_q  <= 1'b0;
    end else begin
      ptr_q  <= ptr_d;
      fill_q <= fill_d;
      hit_q  <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[ptr_q] <= push_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_idx];
    end
  end

  assign rd_data_o = hit_q ? rd_q : 16'd0;

  `AOP_ASSERT(a_no_push_on_read, !(push_i && rd_en_i))
  `AOP_ASSERT(a_fill_bound, fill_q <= FW'(DEPTH))
  `AOP_ASSERT_NEXT(a_push_moves_ptr, push_i, ptr_q != $past(ptr_q))

endmodule

FILE: rtl/core/aop_line_div.sv
module aop_line_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [15:0]       cost_i,
  input  logic [3:0]        unit_i,
  output logic              done_o,
  output aop_pkg::line_res_t res_o
);

  aop_pkg::div_state_e state_q, state_d;

  logic [15:0] cost_q;
  logic [15:0] dvd_q;
  logic [3:0]  unit_q;
  logic [3:0]  rem_q, rem_d;
  logic [3:0]  cnt_q;
  logic [3:0]  rnd_q, rnd_d;
  logic [17:0] n_q;
  logic [15:0] bytes_q;
  logic [4:0]  trial;
  logic [35:0] prod;

  // restoring remainder, one dividend bit per cycle
  always_comb begin
    trial = {rem_q, dvd_q[15]};
    rem_d = (trial >= {1'b0, unit_q}) ? 4'(trial - {1'b0, unit_q}) : trial[3:0];
    rnd_d = (unit_q == 4'd0 || rem_q == 4'd0) ? 4'd0 : unit_q - rem_q;
    prod  = 36'(n_q) * 36'(aop_pkg::DIV3_MAGIC);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      aop_pkg::DV_IDLE: if (start_i) state_d = aop_pkg::DV_RUN;
      aop_pkg::DV_RUN:  if (cnt_q == 4'd0) state_d = aop_pkg::DV_SUM;
      aop_pkg::DV_SUM:  state_d = aop_pkg::DV_MUL;
      aop_pkg::DV_MUL:  state_d = aop_pkg::DV_DONE;
      aop_pkg::DV_DONE: state_d = aop_pkg::DV_IDLE;
      default:          state_d = aop_pkg::DV_IDLE;
    endcase
  end

  always_comb begin
    done_o = (state_q == aop_pkg::DV_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aop_pkg::DV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      aop_pkg::DV_IDLE: begin
        if (start_i) begin
          cost_q <= cost_i;
          dvd_q  <= cost_i;
          unit_q <= unit_i;
          rem_q  <= 4'd0;
          cnt_q  <= 4'd15;
        end
      end
      aop_pkg::DV_RUN: begin
        rem_q <= rem_d;
        dvd_q <= {dvd_q[14:0], 1'b0};
        cnt_q <= cnt_q - 4'd1;
      end
      aop_pkg::DV_SUM: begin
        rnd_q <= rnd_d;
        n_q   <= {({1'b0, cost_q} + {13'd0, rnd_d}), 1'b0};
      end
      aop_pkg::DV_MUL: begin
        bytes_q <= prod[34:19];
      end
      default: begin
      end
    endcase
  end

  assign res_o.rounding_cost = rnd_q;
  assign res_o.line_bytes    = bytes_q;

endmodule

FILE: rtl/core/abbreviation_optimal_parse_unit.sv
// Optimal-parse cost engine for one text line, walked from the last position
// down to position zero. Input requests come on in_valid_i/in_ready_o: one
// character request opens each position, zero or more candidate requests
// follow, and the request flagged last_of_position closes the position and
// yields one output request on out_valid_o/out_ready_i.
// cfg_we_i/cfg_wdata_i write the abbreviation reference cost (reset value 2).
// Flow: a request is accepted in ST_IDLE, where the window memory read
// starts, and is evaluated in ST_EVAL before the next one is taken. A
// closing request also passes ST_EMIT; one of position zero first waits in
// ST_LINE while the line remainder by the rounding unit runs one bit per
// cycle, then for the padded sum and the multiply by 1/3.
// Costs of later positions live in a circular buffer memory of
// MAX_ABBREV_LEN entries with a fill count; a line start resets the fill
// count, so no clearing pass is needed after reset or between lines.
// Reset clears all control state and the current position's cost and pick.
// A stalled receiver holds the output register; the next request is still
// taken and evaluated, and the unit waits only when it has a new result
// and the output register is still full.
`include "abbreviation_optimal_parse_unit_assert.svh"

module abbreviation_optimal_parse_unit #(
  parameter int unsigned MAX_ABBREV_LEN = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [3:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  aop_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output aop_pkg::out_req_t out_req_o
);

  localparam int unsigned AW = $clog2(MAX_ABBREV_LEN);

  aop_pkg::parse_state_e state_q, state_d;
  aop_pkg::in_req_t      item_q;
  aop_pkg::out_req_t     out_q, out_d;
  aop_pkg::line_res_t    line_res;

  logic [3:0]    ref_cost_q;
  logic [15:0]   cur_cost_q, cur_cost_d;
  logic [6:0]    cur_pick_q, cur_pick_d;
  logic          pick_valid_q, pick_valid_d;
  logic [7:0]    pick_weight_q, pick_weight_d;
  logic          out_valid_q;

  logic          accept;
  logic          win_rd_en;
  logic          win_clr;
  logic [AW-1:0] win_k;
  logic [7:0]    len_m1;
  logic [15:0]   win_data;
  logic          emit;
  logic          out_free;
  logic          div_start;
  logic          div_done;
  logic          cand_ok;
  logic [15:0]   cand_cost;
  logic          cand_wins;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // window read address: character requests need the next position,
  // candidates the position abbrev_length further on
  always_comb begin
    len_m1  = {1'b0, in_req_i.abbrev_length} - 8'd1;
    win_k   = (in_req_i.func == aop_pkg::FUNC_CAND) ? AW'(len_m1) : '0;
    win_clr = accept && (in_req_i.func == aop_pkg::FUNC_CHAR) && in_req_i.first_of_line;
  end

  aop_window #(
    .DEPTH (MAX_ABBREV_LEN)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clr_i       (win_clr),
    .rd_en_i     (win_rd_en),
    .rd_k_i      (win_k),
    .push_i      (emit),
    .push_data_i (cur_cost_q),
    .rd_data_o   (win_data)
  );

  aop_line_div u_line_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .cost_i  (cur_cost_d),
    .unit_i  (item_q.rounding_unit),
    .done_o  (div_done),
    .res_o   (line_res)
  );

  // candidate check and compare; ties only displace an earlier abbreviation of no greater weight
  always_comb begin
    cand_ok   = (item_q.abbrev_length != 7'd0) &&
                (int'(item_q.abbrev_length) <= int'(MAX_ABBREV_LEN)) &&
                (int'(item_q.abbrev_id) < int'(aop_pkg::NUM_ABBREVS));
    cand_cost = aop_pkg::sat_add(win_data, ref_cost_q);
    cand_wins = (cand_cost < cur_cost_q) ||
                (pick_valid_q && cand_cost == cur_cost_q &&
                 item_q.abbrev_weight >= pick_weight_q);
  end

  always_comb begin
    cur_cost_d    = cur_cost_q;
    cur_pick_d    = cur_pick_q;
    pick_valid_d  = pick_valid_q;
    pick_weight_d = pick_weight_q;
    if (state_q == aop_pkg::ST_EVAL) begin
      if (item_q.func == aop_pkg::FUNC_CHAR) begin
        cur_cost_d    = aop_pkg::sat_add(win_data, item_q.glyph_cost);
        cur_pick_d    = 7'd0;
        pick_valid_d  = 1'b0;
        pick_weight_d = 8'd0;
      end else if (cand_ok && cand_wins) begin
        cur_cost_d    = cand_cost;
        cur_pick_d    = item_q.abbrev_id;
        pick_valid_d  = 1'b1;
        pick_weight_d = item_q.abbrev_weight;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      aop_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = aop_pkg::ST_EVAL;
      end
      aop_pkg::ST_EVAL: begin
        if (!item_q.last_of_position) begin
          state_d = aop_pkg::ST_IDLE;
        end else if (item_q.last_of_line) begin
          state_d = aop_pkg::ST_LINE;
        end else begin
          state_d = aop_pkg::ST_EMIT;
        end
      end
      aop_pkg::ST_LINE: begin
        if (div_done) state_d = aop_pkg::ST_EMIT;
      end
      aop_pkg::ST_EMIT: begin
        if (out_free) state_d = aop_pkg::ST_IDLE;
      end
      default: state_d = aop_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready_o = (state_q == aop_pkg::ST_IDLE);
    win_rd_en  = (state_q == aop_pkg::ST_IDLE) && in_valid_i;
    div_start  = (state_q == aop_pkg::ST_EVAL) && item_q.last_of_position &&
                 item_q.last_of_line;
    emit       = (state_q == aop_pkg::ST_EMIT) && out_free;
  end

  always_comb begin
    out_d.position_cost = cur_cost_q;
    out_d.picked_valid  = pick_valid_q;
    out_d.picked_id     = pick_valid_q ? cur_pick_q : 7'd0;
    out_d.line_done     = item_q.last_of_line;
    out_d.rounding_cost = item_q.last_of_line ? line_res.rounding_cost : 4'd0;
    out_d.line_bytes    = item_q.last_of_line ? line_res.line_bytes : 16'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= aop_pkg::ST_IDLE;
      ref_cost_q    <= aop_pkg::REF_COST_RESET;
      cur_cost_q    <= 16'd0;
      cur_pick_q    <= 7'd0;
      pick_valid_q  <= 1'b0;
      pick_weight_q <= 8'd0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      cur_cost_q    <= cur_cost_d;
      cur_pick_q    <= cur_pick_d;
      pick_valid_q  <= pick_valid_d;
      pick_weight_q <= pick_weight_d;
      if (cfg_we_i) begin
        ref_cost_q <= cfg_wdata_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_req_i;
    end
    if (emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  `AOP_ASSERT(a_pick_needs_valid, (cur_pick_q != 7'd0) |-> pick_valid_q)
  `AOP_ASSERT(a_div_done_in_line, div_done |-> (state_q == aop_pkg::ST_LINE))
  `AOP_ASSERT_NEXT(a_accept_to_eval, accept, state_q == aop_pkg::ST_EVAL)

endmodule

FILE: dv/abbreviation_optimal_parse_unit_tb.sv
`timescale 1ns / 100ps

module abbreviation_optimal_parse_unit_tb;

  localparam int unsigned MAX_LEN = 64;
  // a closing request at line end waits for the line divider; leave margin
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int LONG_LINE_POSITIONS = 80;

  typedef struct {
    aop_pkg::in_req_t  req;
    bit                pinned;
    aop_pkg::out_req_t res;
  } stim_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     cfg_we = 1'b0;
  logic [3:0] cfg_wdata = 4'd0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  aop_pkg::in_req_t  in_req = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  aop_pkg::out_req_t out_req;

  // traffic shaping, in percent of cycles spent idle
  int unsigned src_idle_pct = 0;
  int unsigned sink_idle_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  // typed-in expectation for the request currently offered
  bit                pin_on = 1'b0;
  aop_pkg::out_req_t pin_res = '0;

  // parse state mirror
  logic [15:0] cost_win [MAX_LEN+1];
  logic [15:0] pos_cost;
  logic [6:0]  pick_id;
  logic        pick_on;
  logic [7:0]  pick_wt;
  logic [3:0]  ref_cost;

  aop_pkg::out_req_t pending_res_q[$];
  stim_row_t         dir_rows[$];
  int                bad_count = 0;

  abbreviation_optimal_parse_unit #(
    .MAX_ABBREV_LEN(MAX_LEN)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_req_o  (out_req)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [15:0] clip_cost(input int unsigned v);
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic void reset_parse_state();
    foreach (cost_win[k]) cost_win[k] = '0;
    pos_cost = '0;
    pick_id  = '0;
    pick_on  = 1'b0;
    pick_wt  = '0;
    ref_cost = aop_pkg::REF_COST_RESET;
  endfunction

  // Mirrors one accepted request; returns 1 when it closes a position.
  function automatic bit predict_parse(input aop_pkg::in_req_t r,
                                       output aop_pkg::out_req_t res);
    int unsigned cand;
    int unsigned unit;
    int unsigned pad;
    int unsigned nbytes;
    res = '0;
    if (r.func == aop_pkg::FUNC_CHAR) begin
      if (r.first_of_line) foreach (cost_win[k]) cost_win[k] = '0;
      pos_cost = clip_cost(cost_win[0] + r.glyph_cost);
      pick_id  = '0;
      pick_on  = 1'b0;
      pick_wt  = '0;
    end else if (r.abbrev_length >= 1 && r.abbrev_length <= MAX_LEN &&
                 r.abbrev_id < aop_pkg::NUM_ABBREVS) begin
      cand = clip_cost(ref_cost + cost_win[r.abbrev_length - 1]);
      // strictly cheaper wins; a tie only displaces another abbreviation
      if (cand < pos_cost ||
          (pick_on && cand == pos_cost && r.abbrev_weight >= pick_wt)) begin
        pos_cost = cand[15:0];
        pick_id  = r.abbrev_id;
        pick_on  = 1'b1;
        pick_wt  = r.abbrev_weight;
      end
    end
    if (!r.last_of_position) return 1'b0;

    pad = 0;
    nbytes = 0;
    if (r.last_of_line) begin
      unit = r.rounding_unit;
      if (unit != 0) pad = (unit - (pos_cost % unit)) % unit;
      nbytes = clip_cost(((pos_cost + pad) * 2) / 3);
    end
    res.position_cost = pos_cost;
    res.picked_valid  = pick_on;
    res.picked_id     = pick_on ? pick_id : 7'd0;
    res.line_done     = r.last_of_line;
    res.rounding_cost = pad[3:0];
    res.line_bytes    = nbytes[15:0];

    for (int k = MAX_LEN; k > 0; k--) cost_win[k] = cost_win[k-1];
    cost_win[0] = pos_cost;
    return 1'b1;
  endfunction

  function automatic aop_pkg::in_req_t char_req(input int cost, input bit first,
                                                input bit lpos, input bit lline,
                                                input int unit);
    aop_pkg::in_req_t r;
    r = '0;
    r.func             = aop_pkg::FUNC_CHAR;
    r.glyph_cost       = 4'(cost);
    r.first_of_line    = first;
    r.last_of_position = lpos;
    r.last_of_line     = lline;
    r.rounding_unit    = 4'(unit);
    return r;
  endfunction

  function automatic aop_pkg::in_req_t cand_req(input int id, input int len,
                                                input int weight, input bit lpos,
                                                input bit lline, input int unit);
    aop_pkg::in_req_t r;
    r = '0;
    r.func             = aop_pkg::FUNC_CAND;
    r.abbrev_id        = 7'(id);
    r.abbrev_length    = 7'(len);
    r.abbrev_weight    = 8'(weight);
    r.last_of_position = lpos;
    r.last_of_line     = lline;
    r.rounding_unit    = 4'(unit);
    return r;
  endfunction

  function automatic aop_pkg::out_req_t line_res(input int cost, input bit ldone,
                                                 input int pad, input int nbytes);
    aop_pkg::out_req_t o;
    o = '0;
    o.position_cost = 16'(cost);
    o.line_done     = ldone;
    o.rounding_cost = 4'(pad);
    o.line_bytes    = 16'(nbytes);
    return o;
  endfunction

  function automatic void add_row(input aop_pkg::in_req_t r, input bit pinned,
                                  input aop_pkg::out_req_t o);
    stim_row_t row;
    row.req = r;
    row.pinned = pinned;
    row.res = o;
    dir_rows.push_back(row);
  endfunction

  // Directed rows, written for reference_cost at its reset value.
  function automatic void load_directed_rows();
    // candidate straight after reset sees zero cost and no pick
    add_row(cand_req(5, 1, 0, 1, 0, 0), 1, line_res(0, 0, 0, 0));
    add_row(char_req(15, 1, 1, 0, 0), 1, line_res(15, 0, 0, 0));
    add_row(char_req(0, 0, 0, 0, 0), 0, '0);
    add_row(cand_req(95, 2, 255, 0, 0, 0), 0, '0);
    // equal cost, equal weight: later abbreviation takes over
    add_row(cand_req(3, 2, 255, 1, 0, 0), 0, '0);
    add_row(char_req(1, 0, 0, 0, 0), 0, '0);
    add_row(cand_req(7, 1, 10, 0, 0, 0), 0, '0);
    // bad index, zero length, overlong lengths: all would win if taken
    add_row(cand_req(96, 3, 0, 0, 0, 0), 0, '0);
    add_row(cand_req(0, 0, 0, 0, 0, 0), 0, '0);
    add_row(cand_req(1, 65, 0, 0, 0, 0), 0, '0);
    add_row(cand_req(127, 127, 255, 0, 0, 0), 0, '0);
    add_row(cand_req(9, 3, 0, 0, 0, 0), 0, '0);
    begin
      aop_pkg::in_req_t r;
      r = cand_req(10, 3, 0, 1, 0, 0);
      r.first_of_line = 1'b1;  // line start flag means nothing on a candidate
      add_row(r, 0, '0);
    end
    // candidate with no character request in front, longest length
    add_row(cand_req(11, 64, 255, 1, 0, 0), 0, '0);
    // tie against the plain character path must not win
    add_row(char_req(0, 0, 0, 0, 0), 0, '0);
    add_row(cand_req(12, 5, 200, 1, 0, 0), 0, '0);
    // tie with a lower weight keeps the earlier pick
    add_row(char_req(5, 0, 0, 0, 0), 0, '0);
    add_row(cand_req(20, 6, 100, 0, 0, 0), 0, '0);
    add_row(cand_req(21, 6, 99, 1, 0, 0), 0, '0);
    // single-position lines: widest unit, zero unit, unit of one, padding
    add_row(char_req(15, 1, 1, 1, 15), 1, line_res(15, 1, 0, 10));
    add_row(char_req(7, 1, 1, 1, 0), 1, line_res(7, 1, 0, 4));
    add_row(char_req(7, 1, 1, 1, 4), 1, line_res(7, 1, 1, 5));
    add_row(char_req(13, 1, 1, 1, 1), 1, line_res(13, 1, 0, 8));
    // two-position line closed by a losing candidate
    add_row(char_req(14, 1, 1, 0, 15), 1, line_res(14, 0, 0, 0));
    add_row(char_req(0, 0, 0, 1, 15), 0, '0);
    add_row(cand_req(95, 1, 255, 1, 1, 15), 0, '0);
  endfunction

  // Offer one request and hold it until taken; returns at a falling edge.
  task automatic offer(input aop_pkg::in_req_t r, input bit pinned,
                       input aop_pkg::out_req_t o);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    pin_on  = pinned;
    pin_res = o;
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Sender pauses until every result is in and the unit has gone quiet.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_res_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_ref_cost(input int unsigned v);
    cfg_we    <= 1'b1;
    cfg_wdata <= 4'(v);
    @(negedge clk);
    cfg_we    <= 1'b0;
    ref_cost = 4'(v);
    @(negedge clk);
  endtask

  // Mostly well-formed lines with random content, some raw noise.
  task automatic run_random_lines(input int n_items);
    int sent;
    int npos;
    int ncand;
    int unit;
    int len;
    int sel;
    logic [63:0] raw;
    aop_pkg::in_req_t r;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9, 0) == 0) begin
        raw = {$urandom, $urandom};
        r = raw[$bits(aop_pkg::in_req_t)-1:0];
        offer(r, 1'b0, '0);
        sent++;
      end else begin
        npos = ($urandom_range(9, 0) == 0) ? $urandom_range(70, 30) : $urandom_range(8, 1);
        unit = $urandom_range(15, 0);
        for (int p = npos - 1; p >= 0; p--) begin
          ncand = $urandom_range(3, 0);
          r = char_req(($urandom_range(3, 0) == 0) ? $urandom_range(15, 0)
                                                   : $urandom_range(3, 0),
                       p == npos - 1, ncand == 0, p == 0, unit);
          offer(r, 1'b0, '0);
          sent++;
          for (int c = 0; c < ncand; c++) begin
            sel = $urandom_range(19, 0);
            if (sel == 0)      len = $urandom_range(1, 0) ? 0 : $urandom_range(127, 65);
            else if (sel < 3)  len = MAX_LEN;
            else if (sel < 6)  len = $urandom_range(MAX_LEN, 1);
            else               len = $urandom_range(8, 1);
            r = cand_req(($urandom_range(19, 0) == 0) ? $urandom_range(127, 96)
                                                      : $urandom_range(95, 0),
                         len,
                         $urandom_range(1, 0) ? $urandom_range(3, 0)
                                              : $urandom_range(255, 0),
                         c == ncand - 1, p == 0, unit);
            r.first_of_line = ($urandom_range(15, 0) == 0);
            offer(r, 1'b0, '0);
            sent++;
          end
        end
      end
    end
  endtask

  // One long line of costly characters, with candidates that reach deep
  // into the window.
  task automatic run_long_line();
    aop_pkg::in_req_t r;
    bit lline;
    for (int p = LONG_LINE_POSITIONS - 1; p >= 0; p--) begin
      lline = (p == 0);
      if (p % 20 == 0) begin
        offer(char_req(15, 0, 0, lline, 7), 1'b0, '0);
        r = cand_req($urandom_range(95, 0), $urandom_range(MAX_LEN, 1),
                     $urandom_range(255, 0), 1, lline, 7);
        offer(r, 1'b0, '0);
      end else begin
        offer(char_req(15, p == LONG_LINE_POSITIONS - 1, 1, lline, 7), 1'b0, '0);
      end
    end
  endtask

  task automatic report_bad(input string what, input aop_pkg::out_req_t e,
                            input aop_pkg::out_req_t a);
    string exp_s;
    string act_s;
    exp_s = $sformatf("exp cost=%0d pv=%0d id=%0d ld=%0d rc=%0d bytes=%0d",
                      e.position_cost, e.picked_valid, e.picked_id, e.line_done,
                      e.rounding_cost, e.line_bytes);
    act_s = $sformatf("act cost=%0d pv=%0d id=%0d ld=%0d rc=%0d bytes=%0d",
                      a.position_cost, a.picked_valid, a.picked_id, a.line_done,
                      a.rounding_cost, a.line_bytes);
    if (bad_count < 10)
      $display("%0t %s: %s | %s", $realtime, what, exp_s, act_s);
    bad_count++;
  endtask

  // Receiver: random back-pressure plus an occasional long hold-off.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99, 0) >= sink_idle_pct);
    end
  end

  // Checker: results first, then the request taken on the same edge.
  always @(posedge clk) begin : scoreboard
    aop_pkg::out_req_t predicted;
    aop_pkg::out_req_t oldest;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_res_q.size() == 0) begin
          report_bad("result with nothing pending", '0, out_req);
        end else begin
          oldest = pending_res_q.pop_front();
          if (oldest.position_cost !== out_req.position_cost ||
              oldest.picked_valid  !== out_req.picked_valid  ||
              oldest.picked_id     !== out_req.picked_id     ||
              oldest.line_done     !== out_req.line_done     ||
              oldest.rounding_cost !== out_req.rounding_cost ||
              oldest.line_bytes    !== out_req.line_bytes)
            report_bad("result mismatch", oldest, out_req);
        end
      end
      if (in_valid && in_ready) begin
        if (predict_parse(in_req, predicted))
          pending_res_q.push_back(pin_on ? pin_res : predicted);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    reset_parse_state();
    load_directed_rows();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // phase 1: sender rarely idle, receiver idle half the time
    src_idle_pct  = 6;
    sink_idle_pct = 49;
    foreach (dir_rows[i]) offer(dir_rows[i].req, dir_rows[i].pinned, dir_rows[i].res);
    drain_results();
    write_ref_cost(0);
    run_random_lines(370);
    drain_results();

    // phase 2: roles swapped; receiver stalls long enough to back up the input
    write_ref_cost(15);
    src_idle_pct  = 49;
    sink_idle_pct = 6;
    run_random_lines(150);
    hold_req = 1'b1;
    run_random_lines(60);
    run_random_lines(160);
    drain_results();

    // phase 3: no idling, with one full pause of the sender midway
    write_ref_cost($urandom_range(14, 1));
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_random_lines(140);
    drain_results();
    run_random_lines(140);
    drain_results();

    write_ref_cost($urandom_range(15, 0));
    run_long_line();
    drain_results();

    if (bad_count == 0 && pending_res_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/aop_pkg.sv
rtl/core/aop_window.sv
rtl/core/aop_line_div.sv
rtl/core/abbreviation_optimal_parse_unit.sv
dv/abbreviation_optimal_parse_unit_tb.sv
